>>> rtl/core/vvbe_pkg.sv
// ----------------------------------------------------------------------------
// vvbe_pkg: shared types and constants of the display register file
// Holds port codes, bank sizes and reset contents of the banks.
// ----------------------------------------------------------------------------
package vvbe_pkg;

   localparam int DispiRegCount  = 12;
   localparam int Vram64kBlocks  = 256;
   localparam int PaletteEntries = 256;
   localparam int PalDepth       = PaletteEntries * 3;
   localparam int PalAddrW       = $clog2(PalDepth);

   // Flat byte store: attr 0..31, seq 32..39, gc 48..63, crt 64..95
   localparam int VgaDepth  = 128;
   localparam int VgaAddrW  = 7;
   localparam logic [VgaAddrW-1:0] VgaAttrBase = 7'd0;
   localparam logic [VgaAddrW-1:0] VgaSeqBase  = 7'd32;
   localparam logic [VgaAddrW-1:0] VgaGcBase   = 7'd48;
   localparam logic [VgaAddrW-1:0] VgaCrtBase  = 7'd64;

   localparam logic [15:0] PortDispiIndex = 16'h01CE;
   localparam logic [15:0] PortDispiData  = 16'h01CF;
   localparam logic [15:0] PortDispiAlias = 16'h01D0;
   localparam logic [15:0] PortAttr       = 16'h03C0;
   localparam logic [15:0] PortAttrRead   = 16'h03C1;
   localparam logic [15:0] PortMisc       = 16'h03C2;
   localparam logic [15:0] PortEnable     = 16'h03C3;
   localparam logic [15:0] PortSeqIndex   = 16'h03C4;
   localparam logic [15:0] PortSeqData    = 16'h03C5;
   localparam logic [15:0] PortDacMask    = 16'h03C6;
   localparam logic [15:0] PortDacRdIdx   = 16'h03C7;
   localparam logic [15:0] PortDacWrIdx   = 16'h03C8;
   localparam logic [15:0] PortDacData    = 16'h03C9;
   localparam logic [15:0] PortFeatRead   = 16'h03CA;
   localparam logic [15:0] PortMiscRead   = 16'h03CC;
   localparam logic [15:0] PortGcIndex    = 16'h03CE;
   localparam logic [15:0] PortGcData     = 16'h03CF;
   localparam logic [15:0] PortCrtIndex   = 16'h03D4;
   localparam logic [15:0] PortCrtData    = 16'h03D5;
   localparam logic [15:0] PortStatColor  = 16'h03DA;
   localparam logic [15:0] PortStatMono   = 16'h03BA;

   localparam logic [3:0] DxId      = 4'd0;
   localparam logic [3:0] DxXres    = 4'd1;
   localparam logic [3:0] DxYres    = 4'd2;
   localparam logic [3:0] DxBpp     = 4'd3;
   localparam logic [3:0] DxEnable  = 4'd4;
   localparam logic [3:0] DxVwidth  = 4'd6;
   localparam logic [3:0] DxVheight = 4'd7;
   localparam logic [3:0] DxXoff    = 4'd8;
   localparam logic [3:0] DxYoff    = 4'd9;
   localparam logic [3:0] DxVmem    = 4'd10;

   localparam logic [15:0] XresMax = 16'd2560;
   localparam logic [15:0] YresMax = 16'd1600;

   typedef struct packed {
      logic        write;
      logic [15:0] port;
      logic [15:0] data;
   } vvbe_req_type;

   function automatic logic [7:0] vvbe_vga_init(input logic [VgaAddrW-1:0] a);
      logic [7:0] r;
      r = 8'h00;
      case (a)
         7'd32: r = 8'h03;
         7'd34: r = 8'h0F;
         7'd36: r = 8'h02;
         7'd53: r = 8'h40;
         7'd54: r = 8'h05;
         7'd64: r = 8'h5F; 7'd65: r = 8'h4F; 7'd66: r = 8'h50; 7'd67: r = 8'h82;
         7'd68: r = 8'h55; 7'd69: r = 8'h81; 7'd70: r = 8'hBF; 7'd71: r = 8'h1F;
         7'd73: r = 8'h4F; 7'd74: r = 8'h0D; 7'd75: r = 8'h0E;
         7'd80: r = 8'h9C; 7'd81: r = 8'h0E; 7'd82: r = 8'h8F;
         7'd85: r = 8'h96; 7'd86: r = 8'hB9; 7'd87: r = 8'hA3;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] vvbe_pal_init(input logic [PalAddrW-1:0] a);
      logic [5:0] r;
      logic [3:0] c;
      logic [1:0] k;
      r = 6'h00;
      c = 4'd0;
      k = 2'd0;
      if (a < PalAddrW'(48)) begin
         for (int i = 0; i < 16; i++) begin
            if (a >= PalAddrW'(3 * i) && a < PalAddrW'(3 * i + 3)) begin
               c = 4'(i);
               k = 2'(a - PalAddrW'(3 * i));
            end
         end
         case (c)
            4'd0: r = 6'h00;
            4'd1: r = (k == 2'd2) ? 6'h2A : 6'h00;
            4'd2: r = (k == 2'd1) ? 6'h2A : 6'h00;
            4'd3: r = (k == 2'd0) ? 6'h00 : 6'h2A;
            4'd4: r = (k == 2'd0) ? 6'h2A : 6'h00;
            4'd5: r = (k == 2'd1) ? 6'h00 : 6'h2A;
            4'd6: r = (k == 2'd0) ? 6'h2A : ((k == 2'd1) ? 6'h15 : 6'h00);
            4'd7: r = 6'h2A;
            4'd8: r = 6'h15;
            4'd9: r = (k == 2'd2) ? 6'h3F : 6'h15;
            4'd10: r = (k == 2'd1) ? 6'h3F : 6'h15;
            4'd11: r = (k == 2'd0) ? 6'h15 : 6'h3F;
            4'd12: r = (k == 2'd0) ? 6'h3F : 6'h15;
            4'd13: r = (k == 2'd1) ? 6'h15 : 6'h3F;
            4'd14: r = (k == 2'd2) ? 6'h15 : 6'h3F;
            default: r = 6'h3F;
         endcase
      end
      return r;
   endfunction

endpackage

>>> rtl/core/vvbe_ram.sv
// ----------------------------------------------------------------------------
// vvbe_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module vvbe_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/vvbe_dispi.sv
// ----------------------------------------------------------------------------
// vvbe_dispi: VBE extension register bank
// Holds the extension registers in flops and applies the write rules.
// ----------------------------------------------------------------------------
module vvbe_dispi #(
   parameter int RegCount  = vvbe_pkg::DispiRegCount,
   parameter int VramBlocks = vvbe_pkg::Vram64kBlocks
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [7:0]  index,
   input  logic [15:0] wr_data,
   output logic [15:0] rd_data
);
   import vvbe_pkg::*;

   logic [15:0] bank_ff [RegCount];
   logic [15:0] bank_in [RegCount];
   logic        in_range;
   logic [3:0]  idx;
   logic [15:0] v;

   function automatic logic [15:0] reset_value(input logic [3:0] i);
      logic [15:0] r;
      r = 16'h0000;
      case (i)
         DxId:      r = 16'hB0C5;
         DxXres:    r = 16'd1024;
         DxYres:    r = 16'd768;
         DxBpp:     r = 16'd32;
         DxVwidth:  r = 16'd1024;
         DxVheight: r = 16'd768;
         DxVmem:    r = 16'(VramBlocks);
         default:   r = 16'h0000;
      endcase
      return r;
   endfunction

   assign in_range = index < 8'(RegCount);
   assign idx      = index[3:0];
   assign rd_data  = in_range ? bank_ff[idx] : 16'h0000;

   always_comb begin
      bank_in = bank_ff;
      v = wr_data;
      if (wr_en && in_range) begin
         unique case (idx)
            DxId: begin
               if (v >= 16'hB0C0 && v <= 16'hB0C5) bank_in[DxId] = v;
            end
            DxXres: begin
               if (v == 16'd0) v = 16'd1;
               if (v > XresMax) v = XresMax;
               bank_in[DxXres]   = v;
               bank_in[DxVwidth] = v;
            end
            DxYres: begin
               if (v == 16'd0) v = 16'd1;
               if (v > YresMax) v = YresMax;
               bank_in[DxYres]    = v;
               bank_in[DxVheight] = v;
            end
            DxBpp: begin
               if (v != 16'd8 && v != 16'd15 && v != 16'd16 && v != 16'd24
                   && v != 16'd32) v = 16'd32;
               bank_in[DxBpp] = v;
            end
            DxEnable: begin
               bank_in[DxEnable] = v;
               if (v[0] && !bank_ff[DxEnable][0]) begin
                  bank_in[DxVwidth] = bank_ff[DxXres];
                  if (bank_ff[DxVheight] < bank_ff[DxYres])
                     bank_in[DxVheight] = bank_ff[DxYres];
                  bank_in[DxXoff] = 16'd0;
                  bank_in[DxYoff] = 16'd0;
               end
            end
            DxVwidth: begin
               bank_in[DxVwidth] = (v == 16'd0) ? 16'd1 : v;
            end
            DxVmem: begin
            end
            default: begin
               bank_in[idx] = v;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RegCount; i++) bank_ff[i] <= reset_value(4'(i));
      end else begin
         bank_ff <= bank_in;
      end
   end
endmodule

>>> rtl/core/vvbe_core.sv
// ----------------------------------------------------------------------------
// vvbe_core: port decoder and sequencer
// Decodes one request, reads or writes the byte and palette memories, and
// forms the response. Runs a clearing/init sweep after reset.
// ----------------------------------------------------------------------------
module vvbe_core #(
   parameter int RegCount   = vvbe_pkg::DispiRegCount,
   parameter int VramBlocks = vvbe_pkg::Vram64kBlocks
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  vvbe_pkg::vvbe_req_type req,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_data
);
   import vvbe_pkg::*;

   localparam logic [1:0] StInit = 2'd0;
   localparam logic [1:0] StIdle = 2'd1;
   localparam logic [1:0] StRead = 2'd2;
   localparam logic [1:0] StResp = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [PalAddrW-1:0] sweep_ff, sweep_in;

   logic [7:0]  dispi_ptr_ff, dispi_ptr_in;
   logic [5:0]  attr_ptr_ff, attr_ptr_in;
   logic        attr_phase_ff, attr_phase_in;
   logic [7:0]  misc_ff, misc_in;
   logic [2:0]  seq_ptr_ff, seq_ptr_in;
   logic [3:0]  gc_ptr_ff, gc_ptr_in;
   logic [4:0]  crt_ptr_ff, crt_ptr_in;
   logic [1:0]  dac_mode_ff, dac_mode_in;
   logic [7:0]  dac_rd_ff, dac_rd_in;
   logic [7:0]  dac_wr_ff, dac_wr_in;
   logic [1:0]  dac_comp_ff, dac_comp_in;
   logic [7:0]  feat_ff, feat_in;
   logic        retrace_ff, retrace_in;
   logic [15:0] rsp_ff, rsp_in;
   logic [1:0]  rsel_ff, rsel_in;

   localparam logic [1:0] RselReg = 2'd0;
   localparam logic [1:0] RselVga = 2'd1;
   localparam logic [1:0] RselPal = 2'd2;

   logic                vga_we;
   logic [VgaAddrW-1:0] vga_addr;
   logic [7:0]          vga_wd, vga_rd;
   logic                pal_we;
   logic [PalAddrW-1:0] pal_addr;
   logic [5:0]          pal_wd, pal_rd;

   logic        dispi_we;
   logic [15:0] dispi_rd;
   logic        take;
   logic [7:0]  b;
   logic [PalAddrW-1:0] pal_base;
   logic [7:0]  dac_ptr_sel;

   vvbe_ram #(.Width(8), .Depth(VgaDepth)) u_vga_ram (
      .clock(clock), .wr_en(vga_we), .addr(vga_addr), .wr_data(vga_wd), .rd_data(vga_rd)
   );
   vvbe_ram #(.Width(6), .Depth(PalDepth)) u_pal_ram (
      .clock(clock), .wr_en(pal_we), .addr(pal_addr), .wr_data(pal_wd), .rd_data(pal_rd)
   );
   vvbe_dispi #(.RegCount(RegCount), .VramBlocks(VramBlocks)) u_dispi (
      .clock(clock), .reset(reset), .wr_en(dispi_we), .index(dispi_ptr_ff),
      .wr_data(req.data), .rd_data(dispi_rd)
   );

   assign req_ready = (state_ff == StIdle);
   assign take      = req_valid && req_ready;
   assign b         = req.data[7:0];
   assign rsp_valid = (state_ff == StResp);
   assign rsp_data  = rsp_ff;
   assign dac_ptr_sel = req.write ? dac_wr_ff : dac_rd_ff;
   assign pal_base  = PalAddrW'(dac_ptr_sel) * PalAddrW'(3) + PalAddrW'(dac_comp_ff);

   always_comb begin
      state_in = state_ff;     sweep_in = sweep_ff;
      dispi_ptr_in = dispi_ptr_ff; attr_ptr_in = attr_ptr_ff;
      attr_phase_in = attr_phase_ff; misc_in = misc_ff;
      seq_ptr_in = seq_ptr_ff; gc_ptr_in = gc_ptr_ff; crt_ptr_in = crt_ptr_ff;
      dac_mode_in = dac_mode_ff; dac_rd_in = dac_rd_ff; dac_wr_in = dac_wr_ff;
      dac_comp_in = dac_comp_ff; feat_in = feat_ff; retrace_in = retrace_ff;
      rsp_in = rsp_ff; rsel_in = rsel_ff;
      vga_we = 1'b0; vga_addr = sweep_ff[VgaAddrW-1:0];
      vga_wd = vvbe_vga_init(sweep_ff[VgaAddrW-1:0]);
      pal_we = 1'b0; pal_addr = sweep_ff; pal_wd = vvbe_pal_init(sweep_ff);
      dispi_we = 1'b0;
      unique case (state_ff)
         StInit: begin
            pal_we = 1'b1;
            vga_we = (sweep_ff < PalAddrW'(VgaDepth));
            if (sweep_ff == PalAddrW'(PalDepth - 1)) state_in = StIdle;
            else sweep_in = sweep_ff + 1'b1;
         end
         StIdle: begin
            if (take) begin
               rsp_in = 16'h0000;
               rsel_in = RselReg;
               state_in = StResp;
               if (req.write) begin
                  case (req.port)
                     PortDispiIndex: dispi_ptr_in = b;
                     PortDispiData, PortDispiAlias: dispi_we = 1'b1;
                     PortAttr: begin
                        if (!attr_phase_ff) attr_ptr_in = b[5:0];
                        else begin
                           vga_we = 1'b1;
                           vga_addr = VgaAttrBase | VgaAddrW'(attr_ptr_ff[4:0]);
                           vga_wd = b;
                        end
                        attr_phase_in = ~attr_phase_ff;
                     end
                     PortMisc: misc_in = b;
                     PortSeqIndex: seq_ptr_in = b[2:0];
                     PortSeqData: begin
                        vga_we = 1'b1; vga_addr = VgaSeqBase | VgaAddrW'(seq_ptr_ff);
                        vga_wd = b;
                     end
                     PortDacRdIdx: begin
                        dac_rd_in = b; dac_comp_in = 2'd0; dac_mode_in = 2'd3;
                     end
                     PortDacWrIdx: begin
                        dac_wr_in = b; dac_comp_in = 2'd0; dac_mode_in = 2'd0;
                     end
                     PortDacData: begin
                        pal_we = 1'b1; pal_addr = pal_base; pal_wd = b[5:0];
                        if (dac_comp_ff == 2'd2) begin
                           dac_comp_in = 2'd0; dac_wr_in = dac_wr_ff + 8'd1;
                        end else dac_comp_in = dac_comp_ff + 2'd1;
                     end
                     PortGcIndex: gc_ptr_in = b[3:0];
                     PortGcData: begin
                        vga_we = 1'b1; vga_addr = VgaGcBase | VgaAddrW'(gc_ptr_ff);
                        vga_wd = b;
                     end
                     PortCrtIndex: crt_ptr_in = b[4:0];
                     PortCrtData: begin
                        vga_we = 1'b1; vga_addr = VgaCrtBase | VgaAddrW'(crt_ptr_ff);
                        vga_wd = b;
                     end
                     PortStatColor, PortStatMono: feat_in = b;
                     default: ;
                  endcase
               end else begin
                  case (req.port)
                     PortDispiIndex: rsp_in = {8'h00, dispi_ptr_ff};
                     PortDispiData:  rsp_in = dispi_rd;
                     PortDispiAlias: rsp_in = 16'hB0C5;
                     PortAttr:       rsp_in = {10'h000, attr_ptr_ff};
                     PortAttrRead: begin
                        if (!attr_ptr_ff[5]) begin
                           vga_addr = VgaAttrBase | VgaAddrW'(attr_ptr_ff[4:0]);
                           rsel_in = RselVga; state_in = StRead;
                        end
                     end
                     PortEnable:   rsp_in = 16'h0001;
                     PortSeqIndex: rsp_in = {13'h0000, seq_ptr_ff};
                     PortSeqData: begin
                        vga_addr = VgaSeqBase | VgaAddrW'(seq_ptr_ff);
                        rsel_in = RselVga; state_in = StRead;
                     end
                     PortDacMask:  rsp_in = 16'h00FF;
                     PortDacRdIdx: rsp_in = {14'h0000, dac_mode_ff};
                     PortDacWrIdx: rsp_in = {8'h00, dac_wr_ff};
                     PortDacData: begin
                        pal_addr = pal_base; rsel_in = RselPal; state_in = StRead;
                        if (dac_comp_ff == 2'd2) begin
                           dac_comp_in = 2'd0; dac_rd_in = dac_rd_ff + 8'd1;
                        end else dac_comp_in = dac_comp_ff + 2'd1;
                     end
                     PortFeatRead: rsp_in = {8'h00, feat_ff};
                     PortMiscRead: rsp_in = {8'h00, misc_ff};
                     PortGcIndex:  rsp_in = {12'h000, gc_ptr_ff};
                     PortGcData: begin
                        vga_addr = VgaGcBase | VgaAddrW'(gc_ptr_ff);
                        rsel_in = RselVga; state_in = StRead;
                     end
                     PortCrtIndex: rsp_in = {11'h000, crt_ptr_ff};
                     PortCrtData: begin
                        vga_addr = VgaCrtBase | VgaAddrW'(crt_ptr_ff);
                        rsel_in = RselVga; state_in = StRead;
                     end
                     PortStatColor, PortStatMono: begin
                        attr_phase_in = 1'b0;
                        retrace_in = ~retrace_ff;
                        rsp_in = retrace_ff ? 16'h0000 : 16'h0009;
                     end
                     default: rsp_in = 16'h0000;
                  endcase
               end
            end
         end
         StRead: begin
            rsp_in = (rsel_ff == RselPal) ? {10'h000, pal_rd} : {8'h00, vga_rd};
            state_in = StResp;
         end
         StResp: begin
            if (rsp_ready) state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StInit; sweep_ff <= '0;
         dispi_ptr_ff <= 8'd0; attr_ptr_ff <= 6'd0; attr_phase_ff <= 1'b0;
         misc_ff <= 8'h67; seq_ptr_ff <= 3'd0; gc_ptr_ff <= 4'd0; crt_ptr_ff <= 5'd0;
         dac_mode_ff <= 2'd0; dac_rd_ff <= 8'd0; dac_wr_ff <= 8'd0; dac_comp_ff <= 2'd0;
         feat_ff <= 8'd0; retrace_ff <= 1'b0; rsel_ff <= RselReg;
      end else begin
         state_ff <= state_in; sweep_ff <= sweep_in;
         dispi_ptr_ff <= dispi_ptr_in; attr_ptr_ff <= attr_ptr_in;
         attr_phase_ff <= attr_phase_in; misc_ff <= misc_in;
         seq_ptr_ff <= seq_ptr_in; gc_ptr_ff <= gc_ptr_in; crt_ptr_ff <= crt_ptr_in;
         dac_mode_ff <= dac_mode_in; dac_rd_ff <= dac_rd_in; dac_wr_ff <= dac_wr_in;
         dac_comp_ff <= dac_comp_in; feat_ff <= feat_in; retrace_ff <= retrace_in;
         rsel_ff <= rsel_in;
      end
      rsp_ff <= rsp_in;
   end
endmodule

>>> rtl/core/vga_vbe_register_file_top.sv
// ----------------------------------------------------------------------------
// vga_vbe_register_file_top: display adapter I/O register file
// One port access per request, one read-data response per request.
//
//   Channel | Direction | Contents
//   req     | in        | tdata = port[15:0], write_data[31:16]; tuser = operation
//   rsp     | out       | tdata = read_data[15:0]
//
// A register result goes from idle straight to the response state; a result from
// the byte or palette RAM passes a read state first, as RAM read data is
// registered. After reset the RAMs are loaded with their initial contents while
// req_tready stays low. A stalled response holds off the next request.
// ----------------------------------------------------------------------------
module vga_vbe_register_file_top #(
   parameter int RegCount   = vvbe_pkg::DispiRegCount,
   parameter int VramBlocks = vvbe_pkg::Vram64kBlocks
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // port[15:0], write_data[31:16]
   input  logic        req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // read_data[15:0]
);
   import vvbe_pkg::*;

   vvbe_req_type req;

   assign req.write = req_tuser;
   assign req.port  = req_tdata[15:0];
   assign req.data  = req_tdata[31:16];

   vvbe_core #(.RegCount(RegCount), .VramBlocks(VramBlocks)) u_core (
      .clock(clock), .reset(reset),
      .req_valid(req_tvalid), .req_ready(req_tready), .req(req),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_data(rsp_tdata)
   );
endmodule

>>> rtl/core/vvbe_checker.sv
// ----------------------------------------------------------------------------
// vvbe_checker: port-level checks of the register file
// Watches request and response ordering on the top-level ports.
// ----------------------------------------------------------------------------
module vvbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("request taken with response pending");
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("second request too early");
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> ##0 (!rsp_tvalid || rsp_tdata == 16'h0000))
      else $error("write returned data");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response dropped");
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |=>
         (req_tvalid && $stable(req_tdata) && $stable(req_tuser)))
      else $error("request changed while waiting");
endmodule

bind vga_vbe_register_file_top vvbe_checker u_vvbe_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tdata(req_tdata), .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the display adapter I/O register file
// Drives port reads and writes on the request stream, predicts the read data
// of each request from a behavioral copy of all register banks and checks
// every response in order, under several idle and stall patterns.
// ----------------------------------------------------------------------------
class port_access_scoreboard;
   logic [7:0]  dispi_idx;
   logic [15:0] dispi_regs[16];
   logic [5:0]  attr_idx;
   logic        attr_flip;
   logic [7:0]  attr_bytes[32];
   logic [7:0]  misc_out;
   logic [2:0]  seq_idx;
   logic [7:0]  seq_bytes[8];
   logic [3:0]  gc_idx;
   logic [7:0]  gc_regs[16];
   logic [4:0]  crt_idx;
   logic [7:0]  crt_regs[32];
   logic [1:0]  dac_mode;
   logic [7:0]  dac_rd;
   logic [7:0]  dac_wr;
   logic [1:0]  dac_comp;
   logic [5:0]  palette[768];
   logic [7:0]  feature;
   logic        retrace;
   logic [15:0] read_queue[$];
   int          failures;

   function void reset_state();
      logic [7:0] crt_init[32];
      logic [5:0] ega[48];
      crt_init = '{8'h5F, 8'h4F, 8'h50, 8'h82, 8'h55, 8'h81, 8'hBF, 8'h1F,
                   8'h00, 8'h4F, 8'h0D, 8'h0E, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h9C, 8'h0E, 8'h8F, 8'h00, 8'h00, 8'h96, 8'hB9, 8'hA3,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      ega = '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h2A, 6'h00, 6'h2A, 6'h00,
              6'h00, 6'h2A, 6'h2A, 6'h2A, 6'h00, 6'h00, 6'h2A, 6'h00, 6'h2A,
              6'h2A, 6'h15, 6'h00, 6'h2A, 6'h2A, 6'h2A, 6'h15, 6'h15, 6'h15,
              6'h15, 6'h15, 6'h3F, 6'h15, 6'h3F, 6'h15, 6'h15, 6'h3F, 6'h3F,
              6'h3F, 6'h15, 6'h15, 6'h3F, 6'h15, 6'h3F, 6'h3F, 6'h3F, 6'h15,
              6'h3F, 6'h3F, 6'h3F};
      dispi_idx = 0;
      foreach (dispi_regs[i]) dispi_regs[i] = 0;
      dispi_regs[vvbe_pkg::DxId] = 16'hB0C5;
      dispi_regs[vvbe_pkg::DxXres] = 1024;
      dispi_regs[vvbe_pkg::DxYres] = 768;
      dispi_regs[vvbe_pkg::DxBpp] = 32;
      dispi_regs[vvbe_pkg::DxVwidth] = 1024;
      dispi_regs[vvbe_pkg::DxVheight] = 768;
      dispi_regs[vvbe_pkg::DxVmem] = 16'(vvbe_pkg::Vram64kBlocks);
      attr_idx = 0;
      attr_flip = 0;
      foreach (attr_bytes[i]) attr_bytes[i] = 0;
      misc_out = 8'h67;
      seq_idx = 0;
      seq_bytes = '{8'h03, 8'h00, 8'h0F, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00};
      gc_idx = 0;
      foreach (gc_regs[i]) gc_regs[i] = 0;
      gc_regs[5] = 8'h40;
      gc_regs[6] = 8'h05;
      crt_idx = 0;
      crt_regs = crt_init;
      dac_mode = 0;
      dac_rd = 0;
      dac_wr = 0;
      dac_comp = 0;
      foreach (palette[i]) palette[i] = (i < 48) ? ega[i] : 6'h00;
      feature = 0;
      retrace = 0;
      failures = 0;
   endfunction

   function void step_dac(ref logic [7:0] ptr);
      if (dac_comp == 2) begin
         dac_comp = 0;
         ptr = ptr + 1;
      end else begin
         dac_comp = dac_comp + 1;
      end
   endfunction

   function void write_dispi(logic [15:0] v);
      logic [15:0] old;
      if (dispi_idx >= vvbe_pkg::DispiRegCount) return;
      case (dispi_idx[3:0])
         vvbe_pkg::DxId: if (v >= 16'hB0C0 && v <= 16'hB0C5) dispi_regs[0] = v;
         vvbe_pkg::DxXres: begin
            if (v == 0) v = 1;
            if (v > vvbe_pkg::XresMax) v = vvbe_pkg::XresMax;
            dispi_regs[vvbe_pkg::DxXres] = v;
            dispi_regs[vvbe_pkg::DxVwidth] = v;
         end
         vvbe_pkg::DxYres: begin
            if (v == 0) v = 1;
            if (v > vvbe_pkg::YresMax) v = vvbe_pkg::YresMax;
            dispi_regs[vvbe_pkg::DxYres] = v;
            dispi_regs[vvbe_pkg::DxVheight] = v;
         end
         vvbe_pkg::DxBpp: begin
            if (!(v == 8 || v == 15 || v == 16 || v == 24 || v == 32)) v = 32;
            dispi_regs[vvbe_pkg::DxBpp] = v;
         end
         vvbe_pkg::DxEnable: begin
            old = dispi_regs[vvbe_pkg::DxEnable];
            dispi_regs[vvbe_pkg::DxEnable] = v;
            if (v[0] && !old[0]) begin
               dispi_regs[vvbe_pkg::DxVwidth] = dispi_regs[vvbe_pkg::DxXres];
               if (dispi_regs[vvbe_pkg::DxVheight] < dispi_regs[vvbe_pkg::DxYres])
                  dispi_regs[vvbe_pkg::DxVheight] = dispi_regs[vvbe_pkg::DxYres];
               dispi_regs[vvbe_pkg::DxXoff] = 0;
               dispi_regs[vvbe_pkg::DxYoff] = 0;
            end
         end
         vvbe_pkg::DxVwidth: dispi_regs[vvbe_pkg::DxVwidth] = (v == 0) ? 16'd1 : v;
         vvbe_pkg::DxVmem: ;
         default: dispi_regs[dispi_idx[3:0]] = v;
      endcase
   endfunction

   function void note_request(logic wr, logic [15:0] port, logic [15:0] v);
      logic [15:0] r;
      logic [7:0]  b;
      r = 0;
      b = v[7:0];
      if (wr) begin
         case (port)
            vvbe_pkg::PortDispiIndex: dispi_idx = b;
            vvbe_pkg::PortDispiData, vvbe_pkg::PortDispiAlias: write_dispi(v);
            vvbe_pkg::PortAttr: begin
               if (!attr_flip) attr_idx = b[5:0];
               else attr_bytes[attr_idx[4:0]] = b;
               attr_flip = !attr_flip;
            end
            vvbe_pkg::PortMisc: misc_out = b;
            vvbe_pkg::PortSeqIndex: seq_idx = b[2:0];
            vvbe_pkg::PortSeqData: seq_bytes[seq_idx] = b;
            vvbe_pkg::PortDacRdIdx: begin
               dac_rd = b; dac_comp = 0; dac_mode = 3;
            end
            vvbe_pkg::PortDacWrIdx: begin
               dac_wr = b; dac_comp = 0; dac_mode = 0;
            end
            vvbe_pkg::PortDacData: begin
               palette[dac_wr * 3 + dac_comp] = b[5:0];
               step_dac(dac_wr);
            end
            vvbe_pkg::PortGcIndex: gc_idx = b[3:0];
            vvbe_pkg::PortGcData: gc_regs[gc_idx] = b;
            vvbe_pkg::PortCrtIndex: crt_idx = b[4:0];
            vvbe_pkg::PortCrtData: crt_regs[crt_idx] = b;
            vvbe_pkg::PortStatColor, vvbe_pkg::PortStatMono: feature = b;
            default: ;
         endcase
      end else begin
         case (port)
            vvbe_pkg::PortDispiIndex: r = dispi_idx;
            vvbe_pkg::PortDispiData:
               r = (dispi_idx < vvbe_pkg::DispiRegCount) ? dispi_regs[dispi_idx[3:0]] : 0;
            vvbe_pkg::PortDispiAlias: r = 16'hB0C5;
            vvbe_pkg::PortAttr: r = attr_idx;
            vvbe_pkg::PortAttrRead: r = (attr_idx < 32) ? attr_bytes[attr_idx[4:0]] : 0;
            vvbe_pkg::PortMisc: r = 0;
            vvbe_pkg::PortEnable: r = 1;
            vvbe_pkg::PortSeqIndex: r = seq_idx;
            vvbe_pkg::PortSeqData: r = seq_bytes[seq_idx];
            vvbe_pkg::PortDacMask: r = 16'h00FF;
            vvbe_pkg::PortDacRdIdx: r = dac_mode;
            vvbe_pkg::PortDacWrIdx: r = dac_wr;
            vvbe_pkg::PortDacData: begin
               r = palette[dac_rd * 3 + dac_comp];
               step_dac(dac_rd);
            end
            vvbe_pkg::PortFeatRead: r = feature;
            vvbe_pkg::PortMiscRead: r = misc_out;
            vvbe_pkg::PortGcIndex: r = gc_idx;
            vvbe_pkg::PortGcData: r = gc_regs[gc_idx];
            vvbe_pkg::PortCrtIndex: r = crt_idx;
            vvbe_pkg::PortCrtData: r = crt_regs[crt_idx];
            vvbe_pkg::PortStatColor, vvbe_pkg::PortStatMono: begin
               attr_flip = 0;
               retrace = !retrace;
               r = retrace ? 16'h0009 : 16'h0000;
            end
            default: r = 0;
         endcase
      end
      read_queue.push_back(r);
   endfunction

   function void check_response(logic [15:0] got, longint now);
      logic [15:0] want;
      if (read_queue.size() == 0) begin
         $display("%0d: unexpected response, expected none, actual %h", now, got);
         failures++;
         return;
      end
      want = read_queue.pop_front();
      if (got !== want) begin
         $display("%0d: read_data mismatch, expected %h, actual %h", now, want, got);
         failures++;
      end
   endfunction
endclass

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = 0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;

   port_access_scoreboard board;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  hold_off = 0;
   int  quiet_cycles = 0;
   bit  busy_accept;

   localparam logic [15:0] KnownPorts[21] = '{
      vvbe_pkg::PortDispiIndex, vvbe_pkg::PortDispiData, vvbe_pkg::PortDispiAlias,
      vvbe_pkg::PortAttr, vvbe_pkg::PortAttrRead, vvbe_pkg::PortMisc,
      vvbe_pkg::PortEnable, vvbe_pkg::PortSeqIndex, vvbe_pkg::PortSeqData,
      vvbe_pkg::PortDacMask, vvbe_pkg::PortDacRdIdx, vvbe_pkg::PortDacWrIdx,
      vvbe_pkg::PortDacData, vvbe_pkg::PortFeatRead, vvbe_pkg::PortMiscRead,
      vvbe_pkg::PortGcIndex, vvbe_pkg::PortGcData, vvbe_pkg::PortCrtIndex,
      vvbe_pkg::PortCrtData, vvbe_pkg::PortStatColor, vvbe_pkg::PortStatMono};

   vga_vbe_register_file_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

   always #1 clock = ~clock;

   always @(posedge clock) begin
      busy_accept = 0;
      if (!reset && req_tvalid && req_tready) begin
         board.note_request(req_tuser, req_tdata[15:0], req_tdata[31:16]);
         busy_accept = 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_response(rsp_tdata, $time);
         busy_accept = 1;
      end
      quiet_cycles = busy_accept ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_request(logic wr, logic [15:0] port, logic [15:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= wr;
      req_tdata <= {v, port};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [15:0] port;
      logic [15:0] v;
      int pick;
      pick = $urandom_range(99);
      if (pick < 85) port = KnownPorts[$urandom_range(20)];
      else if (pick < 92) port = 16'h01C0 + 16'($urandom_range(31));
      else port = 16'($urandom);
      pick = $urandom_range(9);
      if (pick < 3) v = 16'($urandom_range(31));
      else if (pick < 5) v = 16'($urandom_range(3000));
      else if (pick < 6) v = 16'hB0C0 + 16'($urandom_range(7));
      else v = 16'($urandom);
      if (port == vvbe_pkg::PortDispiIndex && $urandom_range(1)) v = 16'($urandom_range(15));
      send_request(1'($urandom_range(1)), port, v);
   endtask

   initial begin
      board = new();
      board.reset_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_request(1'b0, vvbe_pkg::PortDispiAlias, 16'h0000);
      for (int i = 0; i < 12; i++) begin
         send_request(1'b1, vvbe_pkg::PortDispiIndex, 16'(i));
         send_request(1'b0, vvbe_pkg::PortDispiData, 16'h0000);
      end
      send_request(1'b1, vvbe_pkg::PortDispiIndex, 16'(vvbe_pkg::DxId));
      send_request(1'b1, vvbe_pkg::PortDispiData, 16'hB0C2);
      send_request(1'b1, vvbe_pkg::PortDispiData, 16'hFFFF);
      send_request(1'b1, vvbe_pkg::PortDispiIndex, 16'(vvbe_pkg::DxXres));
      send_request(1'b1, vvbe_pkg::PortDispiData, 16'hFFFF);
      send_request(1'b1, vvbe_pkg::PortDispiAlias, 16'h0000);
      send_request(1'b1, vvbe_pkg::PortDispiIndex, 16'(vvbe_pkg::DxBpp));
      send_request(1'b1, vvbe_pkg::PortDispiData, 16'd17);
      send_request(1'b1, vvbe_pkg::PortDispiIndex, 16'(vvbe_pkg::DxEnable));
      send_request(1'b1, vvbe_pkg::PortDispiData, 16'h0001);
      send_request(1'b1, vvbe_pkg::PortDispiIndex, 16'h00FF);
      send_request(1'b0, vvbe_pkg::PortDispiData, 16'h0000);
      for (int i = 0; i < 4; i++) send_request(1'b0, vvbe_pkg::PortDacData, 16'h0000);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 68 : 37) : 0;
         stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 68 : 37) : 0;
         if (ph == 2) hold_off = 300;
         for (int i = 0; i < 330; i++) send_random();
      end
      req_tvalid <= 0;
      send_idle_pct = 0;
      stall_pct = 0;
      while (board.read_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
